// ----- hw/rtl/open_addressing_hash_table_macros.svh -----
// assertion macros used by the hash table rtl
// every macro samples on clk and is disabled while rst_n is low
`ifndef OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH

// same-cycle implication
`define OAHT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oaht assertion failed");

// next-cycle implication
`define OAHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oaht assertion failed");

`endif

// ----- hw/rtl/oaht_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package oaht_pkg;

  localparam int KEY_W    = 32;
  localparam int SLOT_W   = 4;
  localparam int STRIDE_W = 4;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 4'd7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE
  } state_t;

  // request to the home slot unit
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
  } mod_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/oaht_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface oaht_in_if;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [oaht_pkg::KEY_W-1:0] key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface oaht_out_if;
  logic                        valid;
  logic                        ready;
  oaht_pkg::status_t           status;
  logic [oaht_pkg::SLOT_W-1:0] slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/open_addressing_hash_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// open-addressing hash table of 32-bit keys with fixed-stride probing. an insert
// item stores its key in the first free slot on the path home, home+stride, ...
// (all modulo SLOTS) and returns inserted with the slot, or table full once the
// path comes back to the home slot; duplicates are not checked. a search item
// walks the same path and returns found with the slot, or not found on a free
// slot or on returning home. the stride register (reset 7) is taken modulo
// SLOTS and may only be written while the table is idle. one item is worked on
// at a time: the home slot is found by the key register, reciprocal multiply
// and remainder, its read is issued, then the probe loop reads one slot a
// cycle from the key and valid memories, 1 to SLOTS slots in all. the table
// goes back to idle as the result is registered and then accepts the next
// item. a finished result sits in an output register, so the next item is
// accepted while it waits; a later result that finds it still waiting holds
// the probe loop. after reset the valid memory is cleared slot by slot,
// during which no item is accepted.
module open_addressing_hash_table #(
  parameter int SLOTS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  oaht_in_if.sink                              in_item,
  oaht_out_if.source                           out_item,
  input  wire logic                            cfg_wr_en,
  input  wire logic [oaht_pkg::STRIDE_W-1:0]   cfg_wr_data
);

`include "open_addressing_hash_table_macros.svh"

  localparam int IW = $clog2(SLOTS);
  // width that holds both the stride and SLOTS itself
  localparam int CW = (IW + 1 > oaht_pkg::STRIDE_W) ? IW + 1 : oaht_pkg::STRIDE_W;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [IW:0]   SLOTS_I = (IW+1)'(SLOTS);

  // control state
  oaht_pkg::state_t              state_r, state_nxt;
  logic [IW-1:0]                 clr_r;
  logic                          out_valid_r;
  logic [oaht_pkg::STRIDE_W-1:0] stride_r;

  // item payload
  logic                       cmd_r;
  logic [oaht_pkg::KEY_W-1:0] key_r;
  logic [IW-1:0]              step_r;
  logic [IW-1:0]              idx_r;
  logic [IW-1:0]              home_r;
  oaht_pkg::status_t          out_status_r;
  logic [oaht_pkg::SLOT_W-1:0] out_slot_r;

  // memory ports
  logic [IW-1:0]              ram_addr;
  logic                       key_we;
  logic [oaht_pkg::KEY_W-1:0] key_rdata;
  logic                       vld_we;
  logic [0:0]                 vld_wdata;
  logic [0:0]                 vld_rdata;

  // home slot unit
  oaht_pkg::mod_req_t mod_req;
  logic               mod_done;
  logic [IW-1:0]      home_w;

  logic               in_ready;
  logic               in_acc;
  logic               out_free;
  logic               clr_last;
  logic [IW-1:0]      step_w;
  logic [IW-1:0]      idx_step;
  logic               hit_match;
  logic               path_home;
  logic               term;
  logic               commit;
  oaht_pkg::status_t  res_status;
  logic [oaht_pkg::SLOT_W-1:0] res_slot;

  oaht_mod #(.SLOTS(SLOTS)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .done  (mod_done),
    .home  (home_w)
  );

  // key store, never cleared: a key is only looked at behind a set valid bit
  oaht_ram #(.WIDTH(oaht_pkg::KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (key_we),
    .wdata (key_r),
    .rdata (key_rdata)
  );

  // slot valid bits, swept to zero after reset
  oaht_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_vld_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (vld_we),
    .wdata (vld_wdata),
    .rdata (vld_rdata)
  );

  assign in_acc   = in_item.valid && in_ready;
  assign out_free = !out_valid_r || out_item.ready;
  assign clr_last = (clr_r == IW'(SLOTS - 1));

  // stride modulo SLOTS: stride < 16 and SLOTS >= 2, so at most 7 subtracts
  always_comb begin
    logic [CW-1:0] s;
    s = CW'(stride_r);
    for (int j = 0; j < 8; j++) begin
      if (s >= SLOTS_C) begin
        s = s - SLOTS_C;
      end
    end
    step_w = s[IW-1:0];
  end

  // next slot on the probe path, both terms below SLOTS so one correction
  always_comb begin
    logic [IW:0] sum;
    sum = {1'b0, idx_r} + {1'b0, step_r};
    if (sum >= SLOTS_I) begin
      sum = sum - SLOTS_I;
    end
    idx_step = sum[IW-1:0];
  end

  // probe decision on the slot just read
  assign hit_match = (cmd_r == oaht_pkg::CMD_SEARCH) && (key_rdata == key_r);
  assign path_home = (idx_step == home_r);
  assign term      = !vld_rdata[0] || hit_match || path_home;

  always_comb begin
    logic hit;
    if (!vld_rdata[0]) begin
      // free slot ends both commands
      res_status = (cmd_r == oaht_pkg::CMD_INSERT) ? oaht_pkg::ST_INSERTED
                                                   : oaht_pkg::ST_NOT_FOUND;
      hit        = (cmd_r == oaht_pkg::CMD_INSERT);
    end else if (hit_match) begin
      res_status = oaht_pkg::ST_FOUND;
      hit        = 1'b1;
    end else begin
      // path came back home
      res_status = (cmd_r == oaht_pkg::CMD_INSERT) ? oaht_pkg::ST_FULL
                                                   : oaht_pkg::ST_NOT_FOUND;
      hit        = 1'b0;
    end
    res_slot = hit ? oaht_pkg::SLOT_W'(idx_r) : '0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      oaht_pkg::S_CLEAR: begin
        if (clr_last) state_nxt = oaht_pkg::S_IDLE;
      end
      oaht_pkg::S_IDLE: begin
        if (in_acc) state_nxt = oaht_pkg::S_HASH;
      end
      oaht_pkg::S_HASH: begin
        if (mod_done) state_nxt = oaht_pkg::S_PROBE;
      end
      oaht_pkg::S_PROBE: begin
        if (commit) state_nxt = oaht_pkg::S_IDLE;
      end
      default: state_nxt = oaht_pkg::S_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    ram_addr      = idx_r;
    key_we        = 1'b0;
    vld_we        = 1'b0;
    vld_wdata     = 1'b0;
    in_ready      = 1'b0;
    mod_req.start = 1'b0;
    mod_req.key   = in_item.key;
    commit        = 1'b0;
    unique case (state_r)
      oaht_pkg::S_CLEAR: begin
        ram_addr = clr_r;
        vld_we   = 1'b1;
      end
      oaht_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        mod_req.start = in_item.valid;
      end
      oaht_pkg::S_HASH: begin
        // first read goes out as soon as the home slot is known
        ram_addr = home_w;
      end
      oaht_pkg::S_PROBE: begin
        // read ahead along the path; re-read the current slot while held
        ram_addr  = term ? idx_r : idx_step;
        commit    = term && out_free;
        key_we    = commit && !vld_rdata[0] && (cmd_r == oaht_pkg::CMD_INSERT);
        vld_we    = key_we;
        vld_wdata = 1'b1;
      end
      default: begin
        ram_addr = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oaht_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      stride_r    <= oaht_pkg::STRIDE_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == oaht_pkg::S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        stride_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_item.command;
      key_r  <= in_item.key;
      step_r <= step_w;
    end
    if (mod_done) begin
      idx_r  <= home_w;
      home_r <= home_w;
    end else if (state_r == oaht_pkg::S_PROBE && !term) begin
      idx_r <= idx_step;
    end
    if (commit) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
    end
  end

  assign in_item.ready   = in_ready;
  assign out_item.valid  = out_valid_r;
  assign out_item.status = out_status_r;
  assign out_item.slot   = out_slot_r;

  // home slot result only arrives while waiting for it
  `OAHT_ASSERT_SAME(a_done_in_hash, mod_done, state_r == oaht_pkg::S_HASH)
  // probe index and stride stay inside the table
  `OAHT_ASSERT_SAME(a_idx_range, state_r == oaht_pkg::S_PROBE, idx_r < SLOTS && step_r < SLOTS)
  // a search never writes the table
  `OAHT_ASSERT_SAME(a_search_ro, cmd_r == oaht_pkg::CMD_SEARCH && state_r == oaht_pkg::S_PROBE,
    !key_we && !vld_we)
  // a committed result leaves the probe loop and is shown next cycle
  `OAHT_ASSERT_NEXT(a_commit_out, commit, out_valid_r && state_r == oaht_pkg::S_IDLE)

endmodule

`default_nettype wire

// ----- hw/rtl/oaht_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module oaht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    addr,
  input  wire logic             we,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first, registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/oaht_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none

module oaht_mod #(
  parameter int SLOTS = 16,
  localparam int IW = $clog2(SLOTS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire oaht_pkg::mod_req_t req,
  output logic                   done,
  output logic [IW-1:0]          home
);

  // key modulo SLOTS by a constant reciprocal: quotient, then key - q * SLOTS
  localparam int SHIFT   = oaht_pkg::KEY_W + IW;
  localparam int RECIP_W = oaht_pkg::KEY_W + 1;
  localparam int PROD_W  = oaht_pkg::KEY_W + RECIP_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_WIDE);
  localparam logic [IW-1:0]      SLOTS_LO = IW'(SLOTS);

  logic                       mul_r;
  logic                       sub_r;
  logic                       done_r;
  logic [oaht_pkg::KEY_W-1:0] key_r;
  logic [IW-1:0]              quo_r;
  logic [IW-1:0]              rem_r;
  logic [PROD_W-1:0]          prod;
  logic [IW-1:0]              quo_slots;

  assign prod = PROD_W'(key_r) * PROD_W'(RECIP);
  // low bits of the quotient are enough, the remainder is below 2**IW
  assign quo_slots = quo_r * SLOTS_LO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= req.start;
      sub_r  <= mul_r;
      done_r <= sub_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      key_r <= req.key;
    end
    if (mul_r) begin
      quo_r <= prod[SHIFT +: IW];
    end
    if (sub_r) begin
      rem_r <= key_r[IW-1:0] - quo_slots;
    end
  end

  assign done = done_r;
  assign home = rem_r;

endmodule

`default_nettype wire

// ----- tb/sv/open_addressing_hash_table_tb.sv -----
`timescale 1ns / 1ps

module open_addressing_hash_table_tb;
  import oaht_pkg::*;

  localparam int SLOTS       = 16;
  // idle wait after the result queue drains, with margin over the longest item
  localparam int SETTLE_CYC  = 40;
  localparam int POOL_SIZE   = 24;
  localparam int PHASE_ITEMS = 225;

  // one expected result of the table
  typedef struct {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
  } hash_result_t;

  logic clk;
  logic rst_n;
  logic                cfg_wr_en;
  logic [STRIDE_W-1:0] cfg_wr_data;

  oaht_in_if  in_if ();
  oaht_out_if out_if ();

  open_addressing_hash_table #(
    .SLOTS(SLOTS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_if),
    .out_item   (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // shadow copy of the table and the stride register
  logic [KEY_W-1:0]    table_keys [SLOTS];
  logic                table_valid[SLOTS];
  logic [STRIDE_W-1:0] stride_model;

  // results still owed by the block, oldest first
  hash_result_t pending_results[$];
  hash_result_t oldest;

  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  int  mismatches;
  bit  calm;        // no idling on either side when set
  int  stall_left;

  // clock, 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // all block inputs known from time zero
  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_if.valid      = 1'b0;
    in_if.command    = CMD_INSERT;
    in_if.key        = '0;
    out_if.ready     = 1'b0;
    mismatches       = 0;
    calm             = 1'b0;
    stall_left       = 0;
  end

  // walk the probe path home, home+stride, ... exactly as the table does
  function automatic hash_result_t predict_lookup(logic cmd, logic [KEY_W-1:0] key);
    hash_result_t r;
    int unsigned  home;
    int unsigned  idx;
    int unsigned  step;
    int           probes;
    step     = stride_model % SLOTS;
    home     = key % SLOTS;
    idx      = home;
    r.status = (cmd == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
    r.slot   = '0;
    for (probes = 0; probes < SLOTS; probes++) begin
      if (!table_valid[idx]) begin
        if (cmd == CMD_INSERT) begin
          // first free slot takes the key
          table_keys[idx]  = key;
          table_valid[idx] = 1'b1;
          r.status         = ST_INSERTED;
          r.slot           = idx[SLOT_W-1:0];
        end
        return r;
      end
      if (cmd == CMD_SEARCH && table_keys[idx] == key) begin
        r.status = ST_FOUND;
        r.slot   = idx[SLOT_W-1:0];
        return r;
      end
      idx = (idx + step) % SLOTS;
      // back home: path exhausted
      if (idx == home) break;
    end
    return r;
  endfunction

  // send one item, predict its result at the accepting edge
  task automatic send_command(logic cmd, logic [KEY_W-1:0] key);
    @(negedge clk);
    // random sender gap, valid low for the whole burst
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.key     <= key;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(predict_lookup(cmd, key));
  endtask

  // change the stride only once the table has gone quiet
  task automatic write_stride(logic [STRIDE_W-1:0] stride);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= stride;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    stride_model = stride;
  endtask

  // receiver side: ready drops in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(1, 10) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0d slot=%0d", out_if.status, out_if.slot);
      end else begin
        oldest = pending_results.pop_front();
        if (out_if.status !== oldest.status || out_if.slot !== oldest.slot) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected status=%0d slot=%0d, got status=%0d slot=%0d",
                     oldest.status, oldest.slot, out_if.status, out_if.slot);
        end
      end
    end
  end

  // reset stride 7 on an empty table: misses, home hit, collision, top slot
  task automatic test_reset_stride();
    send_command(CMD_SEARCH, 32'h0000_0000);  // empty table
    send_command(CMD_INSERT, 32'h0000_0000);  // home 0
    send_command(CMD_INSERT, 32'h0000_0010);  // collides, moves to 7
    send_command(CMD_SEARCH, 32'h0000_0010);  // found one step out
    send_command(CMD_SEARCH, 32'h0000_0020);  // stops at free slot 14
    send_command(CMD_INSERT, 32'hFFFF_FFFF);  // home 15
    send_command(CMD_SEARCH, 32'hFFFF_FFFF);
  endtask

  // stride zero: only the home slot is ever looked at
  task automatic test_zero_stride();
    write_stride(4'd0);
    send_command(CMD_INSERT, 32'h0000_0020);  // home taken, full at once
    send_command(CMD_SEARCH, 32'h0000_0010);  // lives at 7, not seen
    send_command(CMD_SEARCH, 32'h0000_0000);
    send_command(CMD_INSERT, 32'h8000_0003);  // free home slot still works
  endtask

  // stride 8 covers two slots only: full while the table has room
  task automatic test_half_stride();
    write_stride(4'd8);
    send_command(CMD_INSERT, 32'h0000_0030);  // goes to 8
    send_command(CMD_INSERT, 32'h0000_0040);  // 0 and 8 taken, full
    send_command(CMD_SEARCH, 32'h0000_0040);  // path back home, not found
    send_command(CMD_SEARCH, 32'h0000_0030);
  endtask

  // largest stride steps backwards around the table
  task automatic test_max_stride();
    write_stride(4'd15);
    send_command(CMD_INSERT, 32'h0000_001F);  // 15 taken, lands on 14
    send_command(CMD_SEARCH, 32'h0000_001F);
    send_command(CMD_SEARCH, 32'hFFFF_FFFF);
    send_command(CMD_SEARCH, 32'h7FFF_FFFE);  // not stored
    write_stride(4'd1);
    send_command(CMD_INSERT, 32'h5555_5550);  // linear walk from 0
    send_command(CMD_SEARCH, 32'h5555_5550);
  endtask

  // random traffic: pool keys collide on purpose, insert-then-search pairs
  task automatic test_random_traffic();
    logic [STRIDE_W-1:0] strides[8];
    logic [KEY_W-1:0]    key;
    logic                cmd;
    int                  phase;
    int                  sent;
    strides = '{4'd2, 4'd4, 4'd0, 4'd15, 4'd8, 4'd3, 4'd1, 4'd7};
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = ($urandom & 32'hFFFF_FFF0) | (i % 5);
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 5) write_stride(STRIDE_W'($urandom_range(0, 15)));
      else write_stride(strides[phase]);
      // last phase runs with no idling at all
      if (phase == 7) calm = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        key = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE-1)];
        if ($urandom_range(0, 2) == 0) begin
          // well-formed pair: store a key and look it up right away
          send_command(CMD_INSERT, key);
          send_command(CMD_SEARCH, key);
          sent += 2;
        end else begin
          cmd = 1'($urandom_range(0, 1));
          send_command(cmd, key);
          sent++;
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      table_keys[i]  = '0;
      table_valid[i] = 1'b0;
    end
    stride_model = STRIDE_RESET;
    // reset held from time zero, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_stride();
    test_zero_stride();
    test_half_stride();
    test_max_stride();
    test_random_traffic();

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_if.sv
hw/rtl/oaht_ram.sv
hw/rtl/oaht_mod.sv
hw/rtl/open_addressing_hash_table.sv
tb/sv/open_addressing_hash_table_tb.sv
